[design/smf_track_event_parser_defines.svh]
// Assertion macros shared by the checker of the track event parser.
// Depends on nothing; the including scope provides clock and reset.
`ifndef SMF_TRACK_EVENT_PARSER_DEFINES_SVH
`define SMF_TRACK_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SMF_TEP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smf_tep same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define SMF_TEP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smf_tep next-cycle check failed");

// Behavior in the cycle after reset.
`define SMF_TEP_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("smf_tep reset check failed");

`endif

[design/smf_tep_pkg.sv]
// Package of the track event parser: item types, per-track state, phases and constants.
// Depends on nothing.
package smf_tep_pkg;

   localparam int DEF_MAX_TRACKS = 16;

   localparam logic [7:0] META_OPEN      = 8'hFF;
   localparam logic [7:0] SYSEX_OPEN     = 8'hF0;
   localparam logic [7:0] SYSEX_ESCAPE   = 8'hF7;
   localparam logic [7:0] SYSTEM_FIRST   = 8'hF0;
   localparam logic [7:0] META_END_TRACK = 8'h2F;
   localparam logic [7:0] META_SET_TEMPO = 8'h51;
   localparam logic [2:0] KIND_PROGRAM   = 3'd4;
   localparam logic [2:0] KIND_PRESSURE  = 3'd5;
   localparam logic [2:0] VLQ_MAX_BYTES  = 3'd4;
   localparam logic [27:0] TEMPO_LENGTH  = 28'd3;
   localparam logic [23:0] TEMPO_RESET   = 24'd500000;

   typedef enum logic [3:0] {
      PH_DELTA,
      PH_STATUS,
      PH_CHAN,
      PH_META_TYPE,
      PH_META_LEN,
      PH_META_SKIP,
      PH_TEMPO,
      PH_SYSEX_LEN,
      PH_SYSEX_DATA,
      PH_ENDED,
      PH_FAILED
   } phase_type;

   localparam logic [1:0] TS_RUNNING = 2'd0;
   localparam logic [1:0] TS_ENDED   = 2'd1;
   localparam logic [1:0] TS_ERROR   = 2'd2;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  running_status;
      logic [27:0] vlq_value;
      logic [2:0]  vlq_bytes;
      logic [27:0] bytes_left;
      logic [7:0]  meta_kind;
      logic [31:0] event_time;
   } trk_state_type;

   localparam trk_state_type TRK_RESET = '{phase: PH_DELTA, default: '0};

   typedef struct packed {
      logic [3:0] track_index;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  midi_byte;
      logic [31:0] event_tick;
      logic        tempo_set;
      logic [23:0] tempo_value;
      logic [1:0]  track_status;
      logic        last;
   } rsp_item_type;

   // Number of data bytes that follow a status byte.
   function automatic logic [1:0] data_len(input logic [7:0] status);
      logic [1:0] len;
      if (status >= SYSTEM_FIRST) begin
         len = 2'd0;
      end else if (status[6:4] == KIND_PROGRAM || status[6:4] == KIND_PRESSURE) begin
         len = 2'd1;
      end else begin
         len = 2'd2;
      end
      return len;
   endfunction

endpackage

[design/smf_tep_chan_if.sv]
// Valid/ready channel interface carrying one item of a chosen payload type.
// Depends on nothing; the payload types come from smf_tep_pkg at instantiation.
interface smf_tep_chan_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/smf_track_event_parser.sv]
// Track event parser: an accepted item is registered in stage 1 with its track state, then its results
// in the output register. Throughput is one item per cycle while results are taken; an item with two
// results holds the output register until both are taken, so the next item waits in stage 1.
// The per-track state sits in a small memory whose read is registered and bypassed.
// Synchronous reset marks every track entry invalid at once (invalid reads as reset
// state) and sets the tempo to 500000.
module smf_track_event_parser #(
   parameter int MAX_TRACKS = smf_tep_pkg::DEF_MAX_TRACKS
) (
   input  logic           clock,
   input  logic           reset,
   smf_tep_chan_if.sink   req_chan,
   smf_tep_chan_if.source rsp_chan
);

   localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   typedef logic [IDX_W-1:0] idx_type;

   logic req_fire;
   logic rsp_fire;
   logic req_range;
   idx_type req_idx;
   logic s1_adv;
   logic obuf_free;
   logic wr_en;
   idx_type wr_idx;
   logic bypass;

   logic s1_valid_ff, s1_valid_in;
   logic [3:0] s1_track_ff;
   logic [7:0] s1_byte_ff;
   logic s1_range_ff;

   smf_tep_pkg::trk_state_type trk_mem_ff [MAX_TRACKS];
   logic [MAX_TRACKS-1:0] trk_vld_ff;
   smf_tep_pkg::trk_state_type rd_state_ff;
   logic rd_valid_ff;

   logic [23:0] tempo_ff, tempo_in;

   smf_tep_pkg::trk_state_type cur;
   smf_tep_pkg::trk_state_type nxt;
   logic [1:0] n_out;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic tset;
   logic [31:0] tick;
   logic [1:0] status;
   logic [27:0] vlq_acc;
   logic [2:0] vlq_cnt;
   logic vlq_done;
   logic vlq_over;
   logic [27:0] vlq_val_nx;
   logic [2:0] vlq_cnt_nx;
   logic [27:0] left_dec;
   logic [23:0] tempo_acc;
   logic [1:0] rs_len;
   logic [1:0] b_len;

   logic obuf_valid_ff, obuf_valid_in;
   logic obuf_sel_ff, obuf_sel_in;
   logic obuf_two_ff;
   logic obuf_has_ff;
   logic [7:0] obuf_byte0_ff;
   logic [7:0] obuf_byte1_ff;
   logic [31:0] obuf_tick_ff;
   logic obuf_tset_ff;
   logic [23:0] obuf_tempo_ff;
   logic [1:0] obuf_status_ff;
   smf_tep_pkg::rsp_item_type rsp_item;

   // Handshakes and stage control.
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign obuf_free = !obuf_valid_ff || (rsp_fire && rsp_item.last);
   assign s1_adv    = s1_valid_ff && obuf_free;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign req_range = int'(req_chan.payload.track_index) < MAX_TRACKS;
   assign req_idx   = idx_type'(req_chan.payload.track_index);
   assign wr_en     = s1_adv && s1_range_ff;
   assign wr_idx    = idx_type'(s1_track_ff);
   assign bypass    = wr_en && (wr_idx == req_idx);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_track_ff <= req_chan.payload.track_index;
         s1_byte_ff  <= req_chan.payload.data_byte;
         s1_range_ff <= req_range;
      end
   end

   // Per-track state memory with write-first bypass on the registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         trk_mem_ff[wr_idx] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_range) begin
         if (bypass) begin
            rd_state_ff <= nxt;
            rd_valid_ff <= 1'b1;
         end else begin
            rd_state_ff <= trk_mem_ff[req_idx];
            rd_valid_ff <= trk_vld_ff[req_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_vld_ff <= '0;
      end else if (wr_en) begin
         trk_vld_ff[wr_idx] <= 1'b1;
      end
   end

   // Parse one byte against its track's state.
   always_comb begin
      cur = rd_valid_ff ? rd_state_ff : smf_tep_pkg::TRK_RESET;
      nxt = cur;
      n_out = 2'd0;
      byte0 = 8'd0;
      byte1 = 8'd0;
      tset = 1'b0;
      tempo_in = tempo_ff;

      vlq_acc  = {cur.vlq_value[20:0], s1_byte_ff[6:0]};
      vlq_cnt  = cur.vlq_bytes + 3'd1;
      vlq_done = !s1_byte_ff[7];
      vlq_over = s1_byte_ff[7] && (vlq_cnt >= smf_tep_pkg::VLQ_MAX_BYTES);
      vlq_val_nx = (vlq_done || vlq_over) ? 28'd0 : vlq_acc;
      vlq_cnt_nx = (vlq_done || vlq_over) ? 3'd0 : vlq_cnt;
      left_dec  = cur.bytes_left - 28'd1;
      tempo_acc = {cur.vlq_value[15:0], s1_byte_ff};
      rs_len = smf_tep_pkg::data_len(cur.running_status);
      b_len  = smf_tep_pkg::data_len(s1_byte_ff);

      case (cur.phase)
         smf_tep_pkg::PH_DELTA: begin
            nxt.vlq_value = vlq_val_nx;
            nxt.vlq_bytes = vlq_cnt_nx;
            if (vlq_done) begin
               nxt.event_time = cur.event_time + {4'd0, vlq_acc};
               nxt.phase = smf_tep_pkg::PH_STATUS;
            end else if (vlq_over) begin
               nxt.phase = smf_tep_pkg::PH_FAILED;
            end
         end
         smf_tep_pkg::PH_STATUS: begin
            if (s1_byte_ff[7]) begin
               if (s1_byte_ff == smf_tep_pkg::META_OPEN) begin
                  nxt.running_status = 8'd0;
                  nxt.phase = smf_tep_pkg::PH_META_TYPE;
               end else if (s1_byte_ff == smf_tep_pkg::SYSEX_OPEN ||
                            s1_byte_ff == smf_tep_pkg::SYSEX_ESCAPE) begin
                  nxt.running_status = 8'd0;
                  nxt.meta_kind = s1_byte_ff;
                  nxt.phase = smf_tep_pkg::PH_SYSEX_LEN;
               end else begin
                  nxt.running_status =
                     (s1_byte_ff < smf_tep_pkg::SYSTEM_FIRST) ? s1_byte_ff : 8'd0;
                  n_out = 2'd1;
                  byte0 = s1_byte_ff;
                  nxt.bytes_left = {26'd0, b_len};
                  nxt.phase = (b_len != 2'd0) ? smf_tep_pkg::PH_CHAN : smf_tep_pkg::PH_DELTA;
               end
            end else if (cur.running_status == 8'd0) begin
               nxt.phase = smf_tep_pkg::PH_FAILED;
            end else begin
               n_out = 2'd2;
               byte0 = cur.running_status;
               byte1 = s1_byte_ff;
               nxt.bytes_left = {26'd0, rs_len - 2'd1};
               nxt.phase = (rs_len == 2'd2) ? smf_tep_pkg::PH_CHAN : smf_tep_pkg::PH_DELTA;
            end
         end
         smf_tep_pkg::PH_CHAN, smf_tep_pkg::PH_SYSEX_DATA: begin
            n_out = 2'd1;
            byte0 = s1_byte_ff;
            nxt.bytes_left = left_dec;
            if (left_dec == 28'd0) begin
               nxt.phase = smf_tep_pkg::PH_DELTA;
            end
         end
         smf_tep_pkg::PH_META_TYPE: begin
            nxt.meta_kind = s1_byte_ff;
            nxt.phase = smf_tep_pkg::PH_META_LEN;
         end
         smf_tep_pkg::PH_META_LEN: begin
            nxt.vlq_value = vlq_val_nx;
            nxt.vlq_bytes = vlq_cnt_nx;
            if (vlq_over) begin
               nxt.phase = smf_tep_pkg::PH_FAILED;
            end else if (vlq_done) begin
               if (cur.meta_kind == smf_tep_pkg::META_END_TRACK) begin
                  nxt.phase = smf_tep_pkg::PH_ENDED;
               end else if (cur.meta_kind == smf_tep_pkg::META_SET_TEMPO &&
                            vlq_acc == smf_tep_pkg::TEMPO_LENGTH) begin
                  nxt.bytes_left = smf_tep_pkg::TEMPO_LENGTH;
                  nxt.phase = smf_tep_pkg::PH_TEMPO;
               end else if (vlq_acc == 28'd0) begin
                  nxt.phase = smf_tep_pkg::PH_DELTA;
               end else begin
                  nxt.bytes_left = vlq_acc;
                  nxt.phase = smf_tep_pkg::PH_META_SKIP;
               end
            end
         end
         smf_tep_pkg::PH_META_SKIP: begin
            nxt.bytes_left = left_dec;
            if (left_dec == 28'd0) begin
               nxt.phase = smf_tep_pkg::PH_DELTA;
            end
         end
         smf_tep_pkg::PH_TEMPO: begin
            nxt.vlq_value = {4'd0, tempo_acc};
            nxt.bytes_left = left_dec;
            if (left_dec == 28'd0) begin
               tempo_in = tempo_acc;
               nxt.vlq_value = 28'd0;
               tset = 1'b1;
               nxt.phase = smf_tep_pkg::PH_DELTA;
            end
         end
         smf_tep_pkg::PH_SYSEX_LEN: begin
            nxt.vlq_value = vlq_val_nx;
            nxt.vlq_bytes = vlq_cnt_nx;
            if (vlq_over) begin
               nxt.phase = smf_tep_pkg::PH_FAILED;
            end else if (vlq_done) begin
               n_out = 2'd1;
               byte0 = cur.meta_kind;
               if (vlq_acc == 28'd0) begin
                  nxt.phase = smf_tep_pkg::PH_DELTA;
               end else begin
                  nxt.bytes_left = vlq_acc;
                  nxt.phase = smf_tep_pkg::PH_SYSEX_DATA;
               end
            end
         end
         default: begin
         end
      endcase

      if (!s1_range_ff) begin
         n_out = 2'd0;
         byte0 = 8'd0;
         byte1 = 8'd0;
         tset = 1'b0;
         tempo_in = tempo_ff;
      end

      tick = s1_range_ff ? nxt.event_time : 32'd0;
      if (!s1_range_ff) begin
         status = smf_tep_pkg::TS_RUNNING;
      end else if (nxt.phase == smf_tep_pkg::PH_ENDED) begin
         status = smf_tep_pkg::TS_ENDED;
      end else if (nxt.phase == smf_tep_pkg::PH_FAILED) begin
         status = smf_tep_pkg::TS_ERROR;
      end else begin
         status = smf_tep_pkg::TS_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= smf_tep_pkg::TEMPO_RESET;
      end else if (s1_adv) begin
         tempo_ff <= tempo_in;
      end
   end

   // Output register holds both result items of one input item.
   always_comb begin
      obuf_valid_in = obuf_valid_ff;
      obuf_sel_in = obuf_sel_ff;
      if (s1_adv) begin
         obuf_valid_in = 1'b1;
         obuf_sel_in = 1'b0;
      end else if (rsp_fire) begin
         if (rsp_item.last) begin
            obuf_valid_in = 1'b0;
         end else begin
            obuf_sel_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_valid_ff <= 1'b0;
         obuf_sel_ff <= 1'b0;
      end else begin
         obuf_valid_ff <= obuf_valid_in;
         obuf_sel_ff <= obuf_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         obuf_has_ff    <= (n_out != 2'd0);
         obuf_two_ff    <= (n_out == 2'd2);
         obuf_byte0_ff  <= byte0;
         obuf_byte1_ff  <= byte1;
         obuf_tick_ff   <= tick;
         obuf_tset_ff   <= tset;
         obuf_tempo_ff  <= tempo_in;
         obuf_status_ff <= status;
      end
   end

   always_comb begin
      rsp_item.has_byte     = obuf_has_ff;
      rsp_item.midi_byte    = obuf_sel_ff ? obuf_byte1_ff : obuf_byte0_ff;
      rsp_item.event_tick   = obuf_tick_ff;
      rsp_item.tempo_set    = obuf_tset_ff;
      rsp_item.tempo_value  = obuf_tempo_ff;
      rsp_item.track_status = obuf_status_ff;
      rsp_item.last         = !obuf_two_ff || obuf_sel_ff;
   end

   assign rsp_chan.valid   = obuf_valid_ff;
   assign rsp_chan.payload = rsp_item;

endmodule

[design/smf_tep_checker.sv]
// Port-level checker of the track event parser, bound to the top level.
// Depends on smf_tep_pkg and smf_track_event_parser_defines.svh.
`include "smf_track_event_parser_defines.svh"

module smf_tep_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input smf_tep_pkg::rsp_item_type rsp_item
);

   // An item without a byte carries a zero byte and closes its input's results.
   `SMF_TEP_ASSERT_SAME(a_empty_item, rsp_valid && !rsp_item.has_byte, rsp_item.midi_byte == 8'd0 && rsp_item.last)

   // A completed tempo event never forwards a byte, and the track keeps running.
   `SMF_TEP_ASSERT_SAME(a_tempo_item, rsp_valid && rsp_item.tempo_set, !rsp_item.has_byte && rsp_item.last && rsp_item.track_status == smf_tep_pkg::TS_RUNNING)

   // The second item of a pair follows at once with the same tick and tempo.
   `SMF_TEP_ASSERT_NEXT(a_pair_follows, rsp_valid && rsp_ready && !rsp_item.last, rsp_valid && rsp_item.has_byte && $stable(rsp_item.event_tick) && $stable(rsp_item.tempo_value))

   // A stalled result item holds.
   `SMF_TEP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // Nothing is offered right after reset.
   `SMF_TEP_ASSERT_RESET(a_reset_idle, !rsp_valid)

endmodule

bind smf_track_event_parser smf_tep_checker u_smf_tep_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_item  (rsp_chan.payload)
);
